/* src/segip_pkg.sv */
package segip_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 8;
  // width of the reported coordinates and of the quotient
  localparam int QW = 32;

  typedef enum logic [1:0] {
    HIT_NONE     = 2'd0,
    HIT_POINT    = 2'd1,
    HIT_PARALLEL = 2'd2
  } hit_t;

  // sideband that travels with an item down the pipeline
  typedef struct packed {
    logic valid;
    hit_t status;
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
  } ctl_t;

  typedef struct packed {
    hit_t                 status;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
  } res_t;

endpackage

/* src/segment_intersection_point_unit.sv */
// segment intersection point unit
// input channel: one beat carries segment A (start, end) and segment B (start, end),
//   eight signed coordinates of COORD_BITS each; in_valid / in_stall handshake
// result channel: one beat per input beat, in order: hit status (none, single
//   point, parallel or collinear contact) and the point in signed fixed point
//   with FRAC_BITS fraction bits, truncated toward zero, saturated to 32 bits
// throughput: one beat per cycle, sustained, while the receiver keeps up
// path: a beat taken at the input passes 8 arithmetic stages (differences,
//   products, cross products, split numerator products, two sums, magnitude,
//   range check) and then a chain of 32 divider cells, one quotient bit per
//   cell, and then the output register before it shows on out_valid
// stall: an output register and a one-entry skid stage sit behind the chain;
//   in_stall rises only when the skid stage holds a beat, and the whole pipe
//   freezes until the receiver takes the waiting beat
// reset: rst_n synchronous, active low; all valid flags clear, no beat is lost
//   or invented, in_stall is low the cycle after reset
module segment_intersection_point_unit
  import segip_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_seg_a_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg_a_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg_a_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg_a_end_y,
  input  logic signed [COORD_BITS-1:0] in_seg_b_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg_b_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg_b_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg_b_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_hit_status,
  output logic signed [QW-1:0]         out_cross_x,
  output logic signed [QW-1:0]         out_cross_y
);

  // widths, all sized for exact arithmetic
  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;            // coordinate differences
  localparam int CPW  = 2 * CW + 1;        // line constants c0, c1
  localparam int LW   = CW + 1;            // halves of a split constant
  localparam int PLW  = 2 * LW;            // partial products
  localparam int XW   = 2 * DW + 1;        // cross products and determinant
  localparam int PXW  = 3 * CW + 2;        // recombined numerator products
  localparam int NW   = 3 * CW + 3;        // numerators
  localparam int MAGW = NW + FRAC_BITS;    // scaled numerator magnitude
  localparam int RW   = XW + QW;           // divider remainder
  localparam int CMPW = (MAGW > RW) ? MAGW : RW;

  logic adv, accept;

  // ---------------------------------------------------------------
  // stage 1: register coordinates, differences, bounding box test
  // ---------------------------------------------------------------
  logic                 v1_r, box_r, box_nxt;
  logic signed [CW-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r, x4_r, y4_r;
  logic signed [DW-1:0] a0_1_r, b0_1_r, a1_1_r, b1_1_r;
  logic signed [DW-1:0] ex_r, ey_r, fx_r, fy_r;
  logic signed [DW-1:0] u1x_r, u1y_r, u2x_r, u2y_r, u3x_r, u3y_r, u4x_r, u4y_r;
  logic                 box_x, box_y;

  assign accept = in_valid && !in_stall;

  // max of one pair >= min of the other, written as any-pair compares
  always_comb begin
    box_x = (in_seg_a_start_x >= in_seg_b_start_x || in_seg_a_start_x >= in_seg_b_end_x ||
             in_seg_a_end_x >= in_seg_b_start_x || in_seg_a_end_x >= in_seg_b_end_x) &&
            (in_seg_b_start_x >= in_seg_a_start_x || in_seg_b_start_x >= in_seg_a_end_x ||
             in_seg_b_end_x >= in_seg_a_start_x || in_seg_b_end_x >= in_seg_a_end_x);
    box_y = (in_seg_a_start_y >= in_seg_b_start_y || in_seg_a_start_y >= in_seg_b_end_y ||
             in_seg_a_end_y >= in_seg_b_start_y || in_seg_a_end_y >= in_seg_b_end_y) &&
            (in_seg_b_start_y >= in_seg_a_start_y || in_seg_b_start_y >= in_seg_a_end_y ||
             in_seg_b_end_y >= in_seg_a_start_y || in_seg_b_end_y >= in_seg_a_end_y);
    box_nxt = box_x && box_y;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r   <= in_seg_a_start_x;
      y1_r   <= in_seg_a_start_y;
      x2_r   <= in_seg_a_end_x;
      y2_r   <= in_seg_a_end_y;
      x3_r   <= in_seg_b_start_x;
      y3_r   <= in_seg_b_start_y;
      x4_r   <= in_seg_b_end_x;
      y4_r   <= in_seg_b_end_y;
      box_r  <= box_nxt;
      // line coefficients a = y_start - y_end, b = x_end - x_start
      a0_1_r <= DW'(in_seg_a_start_y) - DW'(in_seg_a_end_y);
      b0_1_r <= DW'(in_seg_a_end_x) - DW'(in_seg_a_start_x);
      a1_1_r <= DW'(in_seg_b_start_y) - DW'(in_seg_b_end_y);
      b1_1_r <= DW'(in_seg_b_end_x) - DW'(in_seg_b_start_x);
      // direction vectors for the straddle tests
      ex_r   <= DW'(in_seg_b_end_x) - DW'(in_seg_b_start_x);
      ey_r   <= DW'(in_seg_b_end_y) - DW'(in_seg_b_start_y);
      fx_r   <= DW'(in_seg_a_start_x) - DW'(in_seg_a_end_x);
      fy_r   <= DW'(in_seg_a_start_y) - DW'(in_seg_a_end_y);
      u1x_r  <= DW'(in_seg_a_start_x) - DW'(in_seg_b_start_x);
      u1y_r  <= DW'(in_seg_a_start_y) - DW'(in_seg_b_start_y);
      u2x_r  <= DW'(in_seg_a_end_x) - DW'(in_seg_b_start_x);
      u2y_r  <= DW'(in_seg_a_end_y) - DW'(in_seg_b_start_y);
      u3x_r  <= DW'(in_seg_b_start_x) - DW'(in_seg_a_end_x);
      u3y_r  <= DW'(in_seg_b_start_y) - DW'(in_seg_a_end_y);
      u4x_r  <= DW'(in_seg_b_end_x) - DW'(in_seg_a_end_x);
      u4y_r  <= DW'(in_seg_b_end_y) - DW'(in_seg_a_end_y);
    end
  end

  // ---------------------------------------------------------------
  // stage 2: all first-level products in parallel
  // ---------------------------------------------------------------
  logic                   v2_r, box2_r;
  logic signed [2*DW-1:0] m1a_r, m1b_r, m2a_r, m2b_r, m3a_r, m3b_r, m4a_r, m4b_r;
  logic signed [2*DW-1:0] da_r, db_r;
  logic signed [2*CW-1:0] c0a_r, c0b_r, c1a_r, c1b_r;
  logic signed [DW-1:0]   a0_2_r, b0_2_r, a1_2_r, b1_2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      box2_r <= box_r;
      m1a_r  <= u1x_r * ey_r;
      m1b_r  <= u1y_r * ex_r;
      m2a_r  <= u2x_r * ey_r;
      m2b_r  <= u2y_r * ex_r;
      m3a_r  <= u3x_r * fy_r;
      m3b_r  <= u3y_r * fx_r;
      m4a_r  <= u4x_r * fy_r;
      m4b_r  <= u4y_r * fx_r;
      c0a_r  <= x1_r * y2_r;
      c0b_r  <= x2_r * y1_r;
      c1a_r  <= x3_r * y4_r;
      c1b_r  <= x4_r * y3_r;
      da_r   <= a0_1_r * b1_1_r;
      db_r   <= a1_1_r * b0_1_r;
      a0_2_r <= a0_1_r;
      b0_2_r <= b0_1_r;
      a1_2_r <= a1_1_r;
      b1_2_r <= b1_1_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 3: cross products, straddle tests, line constants, determinant
  // ---------------------------------------------------------------
  logic signed [XW-1:0]  k1, k2, k3, k4, d_nxt, d3_r;
  logic signed [CPW-1:0] c0_nxt, c1_nxt, c0_r, c1_r;
  logic signed [DW-1:0]  a0_3_r, b0_3_r, a1_3_r, b1_3_r;
  logic                  ok_a, ok_b;
  ctl_t                  ctl3_nxt, ctl3_r;

  always_comb begin
    k1     = XW'(m1a_r) - XW'(m1b_r);
    k2     = XW'(m2a_r) - XW'(m2b_r);
    k3     = XW'(m3a_r) - XW'(m3b_r);
    k4     = XW'(m4a_r) - XW'(m4b_r);
    c0_nxt = CPW'(c0a_r) - CPW'(c0b_r);
    c1_nxt = CPW'(c1a_r) - CPW'(c1b_r);
    d_nxt  = XW'(da_r) - XW'(db_r);
    // ends not strictly on the same side: a zero counts as contact
    ok_a   = (k1 == '0) || (k2 == '0) || (k1[XW-1] != k2[XW-1]);
    ok_b   = (k3 == '0) || (k4 == '0) || (k3[XW-1] != k4[XW-1]);
    ctl3_nxt       = '0;
    ctl3_nxt.valid = v2_r;
    if (!(box2_r && ok_a && ok_b)) begin
      ctl3_nxt.status = HIT_NONE;
    end else if (d_nxt == '0) begin
      ctl3_nxt.status = HIT_PARALLEL;
    end else begin
      ctl3_nxt.status = HIT_POINT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0_r   <= c0_nxt;
      c1_r   <= c1_nxt;
      d3_r   <= d_nxt;
      a0_3_r <= a0_2_r;
      b0_3_r <= b0_2_r;
      a1_3_r <= a1_2_r;
      b1_3_r <= b1_2_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 4: numerator products, constants split in two halves
  // ---------------------------------------------------------------
  logic signed [LW-1:0]  c0_lo, c0_hi, c1_lo, c1_hi;
  logic signed [PLW-1:0] pxl_r, pxh_r, qxl_r, qxh_r, pyl_r, pyh_r, qyl_r, qyh_r;
  logic signed [XW-1:0]  d4_r;
  ctl_t                  ctl4_r;

  assign c0_lo = {1'b0, c0_r[CW-1:0]};
  assign c0_hi = c0_r[CPW-1:CW];
  assign c1_lo = {1'b0, c1_r[CW-1:0]};
  assign c1_hi = c1_r[CPW-1:CW];

  always_ff @(posedge clk) begin
    if (adv) begin
      pxl_r <= b0_3_r * c1_lo;   // b0 * c1
      pxh_r <= b0_3_r * c1_hi;
      qxl_r <= b1_3_r * c0_lo;   // b1 * c0
      qxh_r <= b1_3_r * c0_hi;
      pyl_r <= a1_3_r * c0_lo;   // c0 * a1
      pyh_r <= a1_3_r * c0_hi;
      qyl_r <= a0_3_r * c1_lo;   // c1 * a0
      qyh_r <= a0_3_r * c1_hi;
      d4_r  <= d3_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 5: recombine halves
  // ---------------------------------------------------------------
  logic signed [PXW-1:0] px_r, qx_r, py_r, qy_r;
  logic signed [XW-1:0]  d5_r;
  ctl_t                  ctl5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= (PXW'(pxh_r) <<< CW) + PXW'(pxl_r);
      qx_r <= (PXW'(qxh_r) <<< CW) + PXW'(qxl_r);
      py_r <= (PXW'(pyh_r) <<< CW) + PXW'(pyl_r);
      qy_r <= (PXW'(qyh_r) <<< CW) + PXW'(qyl_r);
      d5_r <= d4_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 6: numerators
  // ---------------------------------------------------------------
  logic signed [NW-1:0] nx_r, ny_r;
  logic signed [XW-1:0] d6_r;
  ctl_t                 ctl6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r <= NW'(px_r) - NW'(qx_r);
      ny_r <= NW'(py_r) - NW'(qy_r);
      d6_r <= d5_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 7: magnitudes, fraction scaling, quotient signs
  // ---------------------------------------------------------------
  logic [NW-1:0]   nx_mag, ny_mag;
  logic [MAGW-1:0] magx_r, magy_r;
  logic [XW-1:0]   d_mag, dmag7_r;
  ctl_t            ctl7_nxt, ctl7_r;

  always_comb begin
    nx_mag = nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
    ny_mag = ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
    d_mag  = d6_r[XW-1] ? XW'(-d6_r) : XW'(d6_r);
    ctl7_nxt       = ctl6_r;
    ctl7_nxt.neg_x = nx_r[NW-1] ^ d6_r[XW-1];
    ctl7_nxt.neg_y = ny_r[NW-1] ^ d6_r[XW-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      magx_r  <= MAGW'(nx_mag) << FRAC_BITS;
      magy_r  <= MAGW'(ny_mag) << FRAC_BITS;
      dmag7_r <= d_mag;
    end
  end

  // ---------------------------------------------------------------
  // stage 8: quotient of 2^32 or more saturates; otherwise load the divider
  // ---------------------------------------------------------------
  logic            ovf_x, ovf_y;
  logic [CMPW-1:0] dlim;
  logic [RW-1:0]   rem8x_r, rem8y_r;
  logic [XW-1:0]   dmag8_r;
  ctl_t            ctl8_nxt, ctl8_r;

  always_comb begin
    dlim           = CMPW'(dmag7_r) << QW;
    ovf_x          = CMPW'(magx_r) >= dlim;
    ovf_y          = CMPW'(magy_r) >= dlim;
    ctl8_nxt       = ctl7_r;
    ctl8_nxt.sat_x = ovf_x;
    ctl8_nxt.sat_y = ovf_y;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem8x_r <= ovf_x ? '0 : RW'(magx_r);
      rem8y_r <= ovf_y ? '0 : RW'(magy_r);
      dmag8_r <= dmag7_r;
    end
  end

  // control flags of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
      ctl7_r <= '0;
      ctl8_r <= '0;
    end else if (adv) begin
      v1_r   <= accept;
      v2_r   <= v1_r;
      ctl3_r <= ctl3_nxt;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
      ctl7_r <= ctl7_nxt;
      ctl8_r <= ctl8_nxt;
    end
  end

  // ---------------------------------------------------------------
  // divider chain: cell i decides quotient bit QW-1-i for both coordinates
  // ---------------------------------------------------------------
  ctl_t          dv_ctl  [0:QW];
  logic [XW-1:0] dv_den  [0:QW];
  logic [RW-1:0] dv_rem_x[0:QW];
  logic [RW-1:0] dv_rem_y[0:QW];
  logic [QW-1:0] dv_q_x  [0:QW];
  logic [QW-1:0] dv_q_y  [0:QW];

  assign dv_ctl[0]   = ctl8_r;
  assign dv_den[0]   = dmag8_r;
  assign dv_rem_x[0] = rem8x_r;
  assign dv_rem_y[0] = rem8y_r;
  assign dv_q_x[0]   = '0;
  assign dv_q_y[0]   = '0;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    segip_div_cell #(
      .DMW (XW),
      .RW  (RW),
      .SH  (QW - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_ctl    (dv_ctl[i]),
      .in_den    (dv_den[i]),
      .in_rem_x  (dv_rem_x[i]),
      .in_rem_y  (dv_rem_y[i]),
      .in_q_x    (dv_q_x[i]),
      .in_q_y    (dv_q_y[i]),
      .out_ctl   (dv_ctl[i+1]),
      .out_den   (dv_den[i+1]),
      .out_rem_x (dv_rem_x[i+1]),
      .out_rem_y (dv_rem_y[i+1]),
      .out_q_x   (dv_q_x[i+1]),
      .out_q_y   (dv_q_y[i+1])
    );
  end

  // ---------------------------------------------------------------
  // result: apply sign, saturate to the signed 32-bit range
  // ---------------------------------------------------------------
  localparam logic [QW-1:0] POS_LIM = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_LIM = {1'b1, {(QW-1){1'b0}}};

  ctl_t          fin_ctl;
  logic [QW-1:0] qx, qy;
  logic          big_x, big_y;
  res_t          res;

  assign fin_ctl = dv_ctl[QW];
  assign qx      = dv_q_x[QW];
  assign qy      = dv_q_y[QW];

  always_comb begin
    // too big: beyond +(2^31 - 1) when positive, beyond 2^31 when negative
    big_x = fin_ctl.sat_x ||
            (fin_ctl.neg_x ? (qx[QW-1] && (qx[QW-2:0] != '0)) : qx[QW-1]);
    big_y = fin_ctl.sat_y ||
            (fin_ctl.neg_y ? (qy[QW-1] && (qy[QW-2:0] != '0)) : qy[QW-1]);
    res        = '0;
    res.status = fin_ctl.status;
    if (fin_ctl.status == HIT_POINT) begin
      if (big_x) begin
        res.x = fin_ctl.neg_x ? NEG_LIM : POS_LIM;
      end else begin
        res.x = fin_ctl.neg_x ? -qx : qx;
      end
      if (big_y) begin
        res.y = fin_ctl.neg_y ? NEG_LIM : POS_LIM;
      end else begin
        res.y = fin_ctl.neg_y ? -qy : qy;
      end
    end
  end

  res_t out_res;

  segip_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fin_ctl.valid),
    .in_data   (res),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_data  (out_res)
  );

  // the pipe stops only while the skid stage holds a beat
  assign in_stall       = !adv;
  assign out_hit_status = out_res.status;
  assign out_cross_x    = out_res.x;
  assign out_cross_y    = out_res.y;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  // a full skid stage always sits behind a valid output beat
  a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall high without a waiting output beat");

  // the point is zero unless a single point was found
  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_status != HIT_POINT) |-> (out_cross_x == '0 && out_cross_y == '0))
    else $error("point nonzero without a single hit");

  // the skid stage fills only behind a stalled output beat
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("skid stage filled while the output was free");

endmodule

/* src/segip_div_cell.sv */
module segip_div_cell
  import segip_pkg::*;
#(
  parameter int DMW = 51,
  parameter int RW  = DMW + QW,
  parameter int SH  = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  ctl_t            in_ctl,
  input  logic [DMW-1:0]  in_den,
  input  logic [RW-1:0]   in_rem_x,
  input  logic [RW-1:0]   in_rem_y,
  input  logic [QW-1:0]   in_q_x,
  input  logic [QW-1:0]   in_q_y,
  output ctl_t            out_ctl,
  output logic [DMW-1:0]  out_den,
  output logic [RW-1:0]   out_rem_x,
  output logic [RW-1:0]   out_rem_y,
  output logic [QW-1:0]   out_q_x,
  output logic [QW-1:0]   out_q_y
);

  localparam logic [QW-1:0] QBIT = QW'(1) << SH;

  ctl_t            ctl_r;
  logic [DMW-1:0]  den_r;
  logic [RW-1:0]   rem_x_r, rem_y_r, rem_x_nxt, rem_y_nxt, den_sh;
  logic [QW-1:0]   q_x_r, q_y_r, q_x_nxt, q_y_nxt;
  logic            take_x, take_y;

  // one restoring step: this cell owns quotient bit SH
  always_comb begin
    den_sh    = RW'(in_den) << SH;
    take_x    = in_rem_x >= den_sh;
    take_y    = in_rem_y >= den_sh;
    rem_x_nxt = take_x ? in_rem_x - den_sh : in_rem_x;
    rem_y_nxt = take_y ? in_rem_y - den_sh : in_rem_y;
    q_x_nxt   = take_x ? (in_q_x | QBIT) : in_q_x;
    q_y_nxt   = take_y ? (in_q_y | QBIT) : in_q_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r   <= in_den;
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      q_x_r   <= q_x_nxt;
      q_y_r   <= q_y_nxt;
    end
  end

  assign out_ctl   = ctl_r;
  assign out_den   = den_r;
  assign out_rem_x = rem_x_r;
  assign out_rem_y = rem_y_r;
  assign out_q_x   = q_x_r;
  assign out_q_y   = q_y_r;

endmodule

/* src/segip_out_skid.sv */
module segip_out_skid
  import segip_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  res_t in_data,
  input  logic out_stall,
  output logic adv,
  output logic out_valid,
  output res_t out_data
);

  logic out_v_r, skid_v_r, out_free, push;
  res_t out_r, skid_r;

  assign adv      = !skid_v_r;
  assign push     = in_valid && adv;
  assign out_free = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        if (out_free) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end
      end else if (push) begin
        if (out_free) begin
          out_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end else if (out_free) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_free) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_free) begin
        out_r <= in_data;
      end else begin
        skid_r <= in_data;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import segip_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY = 40;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    hit_t                 status;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
  } point_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  coord_t in_seg_a_start_x, in_seg_a_start_y, in_seg_a_end_x, in_seg_a_end_y;
  coord_t in_seg_b_start_x, in_seg_b_start_y, in_seg_b_end_x, in_seg_b_end_y;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_hit_status;
  logic signed [QW-1:0] out_cross_x;
  logic signed [QW-1:0] out_cross_y;

  // points still owed by the block, oldest first
  point_t expected_points[$];
  int mismatch_count;
  int beats_sent;
  int points_seen;
  int hits_seen;
  int parallel_seen;
  int idle_cycles;
  // idling control: random bursts while set, cleared for the last stretch
  bit sender_gaps;
  bit receiver_gaps;
  int long_hold;

  segment_intersection_point_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_seg_a_start_x (in_seg_a_start_x),
    .in_seg_a_start_y (in_seg_a_start_y),
    .in_seg_a_end_x   (in_seg_a_end_x),
    .in_seg_a_end_y   (in_seg_a_end_y),
    .in_seg_b_start_x (in_seg_b_start_x),
    .in_seg_b_start_y (in_seg_b_start_y),
    .in_seg_b_end_x   (in_seg_b_end_x),
    .in_seg_b_end_y   (in_seg_b_end_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit_status   (out_hit_status),
    .out_cross_x      (out_cross_x),
    .out_cross_y      (out_cross_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sign of (q - p) x (s - r); coordinates widened so products are exact
  function automatic int turn_sign(longint px, longint py, longint qx, longint qy,
                                   longint rx, longint ry, longint sx, longint sy);
    logic signed [127:0] c;
    c = 128'(qx - px) * 128'(sy - ry) - 128'(qy - py) * 128'(sx - rx);
    if (c == 0) return 0;
    return (c < 0) ? -1 : 1;
  endfunction

  function automatic bit straddles(int s1, int s2);
    return s1 == 0 || s2 == 0 || s1 != s2;
  endfunction

  // signed 128-bit quotient truncated toward zero, clamped to 32 bits
  function automatic logic signed [QW-1:0] clamp_quotient(logic signed [127:0] n,
                                                          logic signed [127:0] d);
    logic signed [127:0] q;
    q = n / d;
    if (q > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (q < -128'sh80000000) return 32'sh80000000;
    return q[QW-1:0];
  endfunction

  function automatic point_t intersect_segments(coord_t ax1, coord_t ay1, coord_t ax2,
                                                coord_t ay2, coord_t bx1, coord_t by1,
                                                coord_t bx2, coord_t by2);
    point_t r;
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [127:0] a0, b0, c0, a1, b1, c1, det, nx, ny;
    x1 = ax1; y1 = ay1; x2 = ax2; y2 = ay2;
    x3 = bx1; y3 = by1; x4 = bx2; y4 = by2;
    r.status = HIT_NONE;
    r.x = '0;
    r.y = '0;
    // bounding boxes must overlap on both axes
    if (((x1 > x2) ? x1 : x2) < ((x3 < x4) ? x3 : x4)) return r;
    if (((x3 > x4) ? x3 : x4) < ((x1 < x2) ? x1 : x2)) return r;
    if (((y3 > y4) ? y3 : y4) < ((y1 < y2) ? y1 : y2)) return r;
    if (((y1 > y2) ? y1 : y2) < ((y3 < y4) ? y3 : y4)) return r;
    if (!straddles(turn_sign(x3, y3, x1, y1, x3, y3, x4, y4),
                   turn_sign(x3, y3, x2, y2, x3, y3, x4, y4))) return r;
    if (!straddles(turn_sign(x2, y2, x3, y3, x2, y2, x1, y1),
                   turn_sign(x2, y2, x4, y4, x2, y2, x1, y1))) return r;
    a0 = 128'(y1 - y2); b0 = 128'(x2 - x1);
    c0 = 128'(x1) * 128'(y2) - 128'(x2) * 128'(y1);
    a1 = 128'(y3 - y4); b1 = 128'(x4 - x3);
    c1 = 128'(x3) * 128'(y4) - 128'(x4) * 128'(y3);
    det = a0 * b1 - a1 * b0;
    if (det == 0) begin
      r.status = HIT_PARALLEL;
      return r;
    end
    nx = (b0 * c1 - b1 * c0) <<< FB;
    ny = (c0 * a1 - c1 * a0) <<< FB;
    r.status = HIT_POINT;
    r.x = clamp_quotient(nx, det);
    r.y = clamp_quotient(ny, det);
    return r;
  endfunction

  // offer one pair of segments and hold it until the block takes it;
  // valid stays up afterwards so the next pair can follow at once
  task automatic send_pair(coord_t ax1, coord_t ay1, coord_t ax2, coord_t ay2,
                           coord_t bx1, coord_t by1, coord_t bx2, coord_t by2);
    int gap;
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_seg_a_start_x <= ax1; in_seg_a_start_y <= ay1;
    in_seg_a_end_x   <= ax2; in_seg_a_end_y   <= ay2;
    in_seg_b_start_x <= bx1; in_seg_b_start_y <= by1;
    in_seg_b_end_x   <= bx2; in_seg_b_end_y   <= by2;
    // the beat is taken at the first rising edge with stall low
    do @(posedge clk); while (in_stall);
    expected_points.insert(expected_points.size(),
                           intersect_segments(ax1, ay1, ax2, ay2, bx1, by1, bx2, by2));
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom());
  endfunction

  // coordinates near a small window so that pairs actually meet
  function automatic coord_t near_coord(int span);
    return coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed_corners();
    coord_t mx, mn;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    // plain crossing of the diagonals
    send_pair(0, 0, 10, 10, 0, 10, 10, 0);
    // far apart boxes
    send_pair(0, 0, 1, 1, 100, 100, 101, 102);
    // boxes overlap but no straddle
    send_pair(0, 0, 10, 10, 0, 1, 4, 10);
    // endpoint on the other segment
    send_pair(0, 0, 10, 0, 5, 0, 5, 7);
    // shared endpoint
    send_pair(-3, -3, 0, 0, 0, 0, 4, -9);
    // collinear overlap, zero determinant
    send_pair(0, 0, 10, 10, 5, 5, 20, 20);
    // degenerate point segments on top of each other
    send_pair(7, 7, 7, 7, 7, 7, 7, 7);
    // point segment lying on the other
    send_pair(3, 3, 3, 3, 0, 0, 6, 6);
    // full range diagonals through the origin area
    send_pair(mn, mn, mx, mx, mn, mx, mx, mn);
    send_pair(mx, mn, mn, mx, mn, mn, mx, mx);
    // extremes on horizontal and vertical segments
    send_pair(mn, 0, mx, 0, 0, mn, 0, mx);
    send_pair(mn, mn, mx, mn, mn, mn, mn, mx);
    send_pair(mx, mx, mn, mx, mx, mx, mx, mn);
    // fractional results, negative quotients
    send_pair(0, 0, 3, 1, 0, 1, 1, 0);
    send_pair(0, 0, -3, -1, 0, -1, -1, 0);
    send_pair(-1, 2, 2, -7, -5, -5, 3, 1);
    // near parallel lines crossing at extreme range
    send_pair(mn, mn, mx, mx - coord_t'(1), mn, mn + coord_t'(1), mx, mx);
    // all ones and all zeros patterns
    send_pair(-1, -1, -1, -1, 0, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
    wait_drained();
  endtask

  task automatic test_random_pairs(int count, int span);
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: send_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), rand_coord());
        1: send_pair(near_coord(span), near_coord(span), near_coord(span), near_coord(span),
                     near_coord(span), near_coord(span), near_coord(span), near_coord(span));
        2: begin
          // crossing by construction: b runs across the segment a
          coord_t cx, cy;
          cx = rand_coord(); cy = rand_coord();
          send_pair(cx, cy, -cx, -cy, -cy, cx, cy, -cx);
        end
        default: begin
          // collinear or parallel on a shared line, small steps
          coord_t ox, oy, dx, dy;
          ox = near_coord(span); oy = near_coord(span);
          dx = near_coord(50); dy = near_coord(50);
          send_pair(ox, oy, ox + dx, oy + dy, ox + dx + dx, oy + dy + dy,
                    ox - dx, oy - dy);
        end
      endcase
    end
  endtask

  // receiver holds off long enough for the pipe and skid stage to fill
  task automatic test_backpressure_fill();
    long_hold = 120;
    test_random_pairs(80, 1000);
    wait_drained();
  endtask

  task automatic test_streaming_no_idle();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_random_pairs(300, 500);
    wait_drained();
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    int burst;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        repeat (long_hold) @(negedge clk);
        long_hold = 0;
        out_stall <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result check against the oldest owed point
  always @(posedge clk) begin
    point_t exp_pt;
    if (rst_n && out_valid && !out_stall) begin
      points_seen++;
      if (expected_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected beat: status %0d x %0d y %0d",
                   out_hit_status, out_cross_x, out_cross_y);
      end else begin
        exp_pt = expected_points.pop_front();
        if (exp_pt.status == HIT_POINT) hits_seen++;
        if (exp_pt.status == HIT_PARALLEL) parallel_seen++;
        if (out_hit_status !== exp_pt.status || out_cross_x !== exp_pt.x ||
            out_cross_y !== exp_pt.y) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("beat %0d: expected status %0d x %0d y %0d, got status %0d x %0d y %0d",
                     points_seen, exp_pt.status, exp_pt.x, exp_pt.y,
                     out_hit_status, out_cross_x, out_cross_y);
        end
      end
    end
  end

  // watchdog: cycles in which neither channel moves a beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d points owed", expected_points.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    beats_sent = 0;
    points_seen = 0;
    hits_seen = 0;
    parallel_seen = 0;
    idle_cycles = 0;
    long_hold = 0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_seg_a_start_x, in_seg_a_start_y, in_seg_a_end_x, in_seg_a_end_y} = '0;
    {in_seg_b_start_x, in_seg_b_start_y, in_seg_b_end_x, in_seg_b_end_y} = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed_corners();
    test_backpressure_fill();
    // after this batch the sender pauses until every owed point has come back
    test_random_pairs(1200, 100000);
    wait_drained();
    test_random_pairs(400, 40);
    wait_drained();
    test_streaming_no_idle();
    repeat (LATENCY + 10) @(negedge clk);
    $display("sent %0d segment pairs, checked %0d results (%0d points, %0d parallel)",
             beats_sent, points_seen, hits_seen, parallel_seen);
    $display("covered corners, random pairs, long backpressure and full-rate streaming");
    if (mismatch_count == 0 && expected_points.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d points missing", mismatch_count,
               expected_points.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
